FILE: sv/hist2d_pkg.sv
// Shared types, codes and default constants for the 2D histogram block.
package hist2d_pkg;

	// Fixed field widths
	localparam int unsigned EDGE_W    = 32;
	localparam int unsigned BIN_CNT_W = 7;
	localparam int unsigned IDX_OUT_W = 6;
	localparam int unsigned OUT_CNT_W = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// Parameter defaults
	localparam int unsigned MAX_X_BINS_DEF  = 64;
	localparam int unsigned MAX_Y_BINS_DEF  = 64;
	localparam int unsigned COUNT_WIDTH_DEF = 32;

	// Register reset values
	localparam logic signed [EDGE_W-1:0] LOW_EDGE_RST  = 32'sd0;
	localparam logic signed [EDGE_W-1:0] HIGH_EDGE_RST = 32'sd65536;
	localparam logic [BIN_CNT_W-1:0]     BIN_CNT_RST   = 7'd64;

	// Request codes
	localparam logic REQ_FILL = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_LOW_EDGE  = 3'd0,
		REG_X_HIGH_EDGE = 3'd1,
		REG_X_BIN_COUNT = 3'd2,
		REG_Y_LOW_EDGE  = 3'd3,
		REG_Y_HIGH_EDGE = 3'd4,
		REG_Y_BIN_COUNT = 3'd5
	} cfg_reg_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_DIV,
		ST_RD,
		ST_FIN
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clr;
		logic load;
		logic prep;
		logic div_step;
		logic mem_rd;
		logic finish;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic is_read;
		logic clr_last;
		logic div_last;
		logic out_free;
	} sts_t;

	// Commands into one axis lane
	typedef struct packed {
		logic load;
		logic prep;
		logic step_en;
	} lane_cmd_t;

endpackage

FILE: sv/hist2d_lane.sv
// One axis lane: range check, flow counters and restoring bin divider.
module hist2d_lane #(
	parameter int unsigned MAX_BINS    = hist2d_pkg::MAX_X_BINS_DEF,
	parameter int unsigned COUNT_WIDTH = hist2d_pkg::COUNT_WIDTH_DEF,
	localparam int unsigned QB = ($clog2(MAX_BINS) > 0) ? $clog2(MAX_BINS) : 1,
	localparam int unsigned SW = ($clog2(QB) > 0) ? $clog2(QB) : 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  hist2d_pkg::lane_cmd_t                  cmd,
	input  logic signed [hist2d_pkg::EDGE_W-1:0]   sample,
	input  logic signed [hist2d_pkg::EDGE_W-1:0]   low_edge,
	input  logic signed [hist2d_pkg::EDGE_W-1:0]   high_edge,
	input  logic [hist2d_pkg::BIN_CNT_W-1:0]       bin_count,
	input  logic [SW-1:0]                          step,
	output logic                                   in_bin,
	output logic [QB-1:0]                          idx,
	output logic [COUNT_WIDTH-1:0]                 over_cnt,
	output logic [COUNT_WIDTH-1:0]                 under_cnt
);

	localparam int unsigned NW = $clog2(MAX_BINS + 1);
	localparam int unsigned PW = NW + hist2d_pkg::EDGE_W;

	logic signed [hist2d_pkg::EDGE_W-1:0] v_q;
	logic                                 over_q;
	logic                                 under_q;
	logic [PW-1:0]                        rem_q;
	logic [hist2d_pkg::EDGE_W-1:0]        den_q;
	logic [QB-1:0]                        quo_q;
	logic [COUNT_WIDTH-1:0]               over_cnt_q;
	logic [COUNT_WIDTH-1:0]               under_cnt_q;

	logic                                 is_over;
	logic                                 is_under;
	logic [NW-1:0]                        n_eff;
	logic [hist2d_pkg::EDGE_W:0]          off_w;
	logic [hist2d_pkg::EDGE_W:0]          span_w;
	logic [PW-1:0]                        prod;
	logic [PW-1:0]                        den_sh;

	// Classification and clamped bin count
	always_comb begin
		is_over  = (v_q >= high_edge);
		is_under = !is_over && (v_q < low_edge);
		if (bin_count == '0) begin
			n_eff = NW'(1);
		end else if (int'(bin_count) > int'(MAX_BINS)) begin
			n_eff = NW'(MAX_BINS);
		end else begin
			n_eff = NW'(bin_count);
		end
		off_w  = {v_q[hist2d_pkg::EDGE_W-1], v_q} - {low_edge[hist2d_pkg::EDGE_W-1], low_edge};
		span_w = {high_edge[hist2d_pkg::EDGE_W-1], high_edge}
			- {low_edge[hist2d_pkg::EDGE_W-1], low_edge};
		prod   = PW'(n_eff) * PW'(off_w[hist2d_pkg::EDGE_W-1:0]);
		den_sh = PW'(den_q) << step;
	end

	// Sample capture, classify, one quotient bit per divide step
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= sample;
		end
		if (cmd.prep) begin
			over_q  <= is_over;
			under_q <= is_under;
			rem_q   <= prod;
			den_q   <= span_w[hist2d_pkg::EDGE_W-1:0];
			quo_q   <= '0;
		end else if (cmd.step_en) begin
			if (rem_q >= den_sh) begin
				rem_q       <= rem_q - den_sh;
				quo_q[step] <= 1'b1;
			end
		end
	end

	// Saturating flow counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			over_cnt_q  <= '0;
			under_cnt_q <= '0;
		end else if (cmd.prep) begin
			if (is_over && (over_cnt_q != '1)) begin
				over_cnt_q <= over_cnt_q + 1'b1;
			end
			if (is_under && (under_cnt_q != '1)) begin
				under_cnt_q <= under_cnt_q + 1'b1;
			end
		end
	end

	assign in_bin    = !over_q && !under_q;
	assign idx       = quo_q;
	assign over_cnt  = over_cnt_q;
	assign under_cnt = under_cnt_q;

endmodule

FILE: sv/hist2d_dp.sv
// Datapath: configuration registers, axis lanes, bin memory and result register.
module hist2d_dp #(
	parameter int unsigned MAX_X_BINS  = hist2d_pkg::MAX_X_BINS_DEF,
	parameter int unsigned MAX_Y_BINS  = hist2d_pkg::MAX_Y_BINS_DEF,
	parameter int unsigned COUNT_WIDTH = hist2d_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  hist2d_pkg::cmd_t                        cmd,
	output hist2d_pkg::sts_t                        sts,
	input  logic                                    cfg_we,
	input  logic [hist2d_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hist2d_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                    req_type,
	input  logic signed [hist2d_pkg::EDGE_W-1:0]    sample_x,
	input  logic signed [hist2d_pkg::EDGE_W-1:0]    sample_y,
	input  logic [hist2d_pkg::IDX_OUT_W-1:0]        read_bin_x,
	input  logic [hist2d_pkg::IDX_OUT_W-1:0]        read_bin_y,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic                                    in_range,
	output logic [hist2d_pkg::IDX_OUT_W-1:0]        bin_x_index,
	output logic [hist2d_pkg::IDX_OUT_W-1:0]        bin_y_index,
	output logic [hist2d_pkg::OUT_CNT_W-1:0]        bin_value,
	output logic [hist2d_pkg::OUT_CNT_W-1:0]        x_over_total,
	output logic [hist2d_pkg::OUT_CNT_W-1:0]        x_under_total,
	output logic [hist2d_pkg::OUT_CNT_W-1:0]        y_over_total,
	output logic [hist2d_pkg::OUT_CNT_W-1:0]        y_under_total
);

	localparam int unsigned DEPTH = MAX_X_BINS * MAX_Y_BINS;
	localparam int unsigned AW    = ($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1;
	localparam int unsigned QBX   = ($clog2(MAX_X_BINS) > 0) ? $clog2(MAX_X_BINS) : 1;
	localparam int unsigned QBY   = ($clog2(MAX_Y_BINS) > 0) ? $clog2(MAX_Y_BINS) : 1;
	localparam int unsigned QB    = (QBX > QBY) ? QBX : QBY;
	localparam int unsigned SW    = ($clog2(QB) > 0) ? $clog2(QB) : 1;
	localparam int unsigned OW    = (COUNT_WIDTH > hist2d_pkg::OUT_CNT_W) ?
		COUNT_WIDTH : hist2d_pkg::OUT_CNT_W;

	// Configuration registers
	logic signed [hist2d_pkg::EDGE_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q;
	logic [hist2d_pkg::BIN_CNT_W-1:0]     x_cnt_q, y_cnt_q;

	// Request registers
	logic                                 req_type_q;
	logic [hist2d_pkg::IDX_OUT_W-1:0]     rbx_q, rby_q;

	// Divider step and clearing sweep
	logic [SW-1:0]                        step_q;
	logic [AW-1:0]                        clr_q;

	// Memory
	logic [COUNT_WIDTH-1:0]               mem [DEPTH];
	logic [COUNT_WIDTH-1:0]               rd_q;
	logic                                 rd_ok_q;
	logic [AW-1:0]                        addr_q;

	// Result register
	logic                                 out_valid_q;
	logic                                 in_range_q;
	logic [hist2d_pkg::IDX_OUT_W-1:0]     bx_q, by_q;
	logic [hist2d_pkg::OUT_CNT_W-1:0]     val_q, xo_q, xu_q, yo_q, yu_q;

	// Lane wiring
	hist2d_pkg::lane_cmd_t                lcmd_x, lcmd_y;
	logic                                 x_in, y_in;
	logic [QBX-1:0]                       ix;
	logic [QBY-1:0]                       iy;
	logic [COUNT_WIDTH-1:0]               xo_cnt, xu_cnt, yo_cnt, yu_cnt;

	logic                                 fill_hit;
	logic                                 rd_ok;
	logic [AW-1:0]                        rd_addr;
	logic [COUNT_WIDTH-1:0]               inc_val;
	logic [COUNT_WIDTH-1:0]               res_val;
	logic                                 mem_we;
	logic [AW-1:0]                        mem_wa;
	logic [COUNT_WIDTH-1:0]               mem_wd;
	logic [OW-1:0]                        val_w, xo_w, xu_w, yo_w, yu_w;

	// Configuration write decode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q  <= hist2d_pkg::LOW_EDGE_RST;
			x_high_q <= hist2d_pkg::HIGH_EDGE_RST;
			x_cnt_q  <= hist2d_pkg::BIN_CNT_RST;
			y_low_q  <= hist2d_pkg::LOW_EDGE_RST;
			y_high_q <= hist2d_pkg::HIGH_EDGE_RST;
			y_cnt_q  <= hist2d_pkg::BIN_CNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hist2d_pkg::REG_X_LOW_EDGE:  x_low_q  <= cfg_data;
				hist2d_pkg::REG_X_HIGH_EDGE: x_high_q <= cfg_data;
				hist2d_pkg::REG_X_BIN_COUNT: x_cnt_q  <= cfg_data[hist2d_pkg::BIN_CNT_W-1:0];
				hist2d_pkg::REG_Y_LOW_EDGE:  y_low_q  <= cfg_data;
				hist2d_pkg::REG_Y_HIGH_EDGE: y_high_q <= cfg_data;
				hist2d_pkg::REG_Y_BIN_COUNT: y_cnt_q  <= cfg_data[hist2d_pkg::BIN_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req_type;
			rbx_q      <= read_bin_x;
			rby_q      <= read_bin_y;
		end
	end

	// Lane commands: flow counters only move on fills
	always_comb begin
		lcmd_x.load    = cmd.load;
		lcmd_x.prep    = cmd.prep && (req_type_q == hist2d_pkg::REQ_FILL);
		lcmd_x.step_en = cmd.div_step && (int'(step_q) < int'(QBX));
		lcmd_y.load    = cmd.load;
		lcmd_y.prep    = lcmd_x.prep;
		lcmd_y.step_en = cmd.div_step && (int'(step_q) < int'(QBY));
	end

	hist2d_lane #(
		.MAX_BINS    (MAX_X_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (lcmd_x),
		.sample    (sample_x),
		.low_edge  (x_low_q),
		.high_edge (x_high_q),
		.bin_count (x_cnt_q),
		.step      ($clog2(QBX) > 0 ? step_q[(($clog2(QBX) > 0) ? $clog2(QBX) : 1)-1:0]
			: step_q[0:0]),
		.in_bin    (x_in),
		.idx       (ix),
		.over_cnt  (xo_cnt),
		.under_cnt (xu_cnt)
	);

	hist2d_lane #(
		.MAX_BINS    (MAX_Y_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (lcmd_y),
		.sample    (sample_y),
		.low_edge  (y_low_q),
		.high_edge (y_high_q),
		.bin_count (y_cnt_q),
		.step      ($clog2(QBY) > 0 ? step_q[(($clog2(QBY) > 0) ? $clog2(QBY) : 1)-1:0]
			: step_q[0:0]),
		.in_bin    (y_in),
		.idx       (iy),
		.over_cnt  (yo_cnt),
		.under_cnt (yu_cnt)
	);

	// Divide step counter, counts down from the top quotient bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.prep) begin
			step_q <= SW'(QB - 1);
		end else if (cmd.div_step && (step_q != '0)) begin
			step_q <= step_q - 1'b1;
		end
	end

	// Clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Address and write data selection
	always_comb begin
		fill_hit = (req_type_q == hist2d_pkg::REQ_FILL) && x_in && y_in;
		if (req_type_q == hist2d_pkg::REQ_READ) begin
			rd_ok   = (int'(rbx_q) < int'(MAX_X_BINS)) && (int'(rby_q) < int'(MAX_Y_BINS));
			rd_addr = AW'(AW'(rbx_q) * AW'(MAX_Y_BINS) + AW'(rby_q));
		end else begin
			rd_ok   = 1'b1;
			rd_addr = AW'(AW'(ix) * AW'(MAX_Y_BINS) + AW'(iy));
		end
		inc_val = (rd_q == '1) ? rd_q : rd_q + 1'b1;
		if (req_type_q == hist2d_pkg::REQ_READ) begin
			res_val = rd_ok_q ? rd_q : '0;
		end else begin
			res_val = fill_hit ? inc_val : '0;
		end
		mem_we = cmd.clr || (cmd.finish && fill_hit);
		mem_wa = cmd.clr ? clr_q : addr_q;
		mem_wd = cmd.clr ? '0 : inc_val;
	end

	// Bin memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			rd_q    <= mem[rd_addr];
			rd_ok_q <= rd_ok;
			addr_q  <= rd_addr;
		end
	end

	// Widen counts so the low word can always be taken
	always_comb begin
		val_w = OW'(res_val);
		xo_w  = OW'(xo_cnt);
		xu_w  = OW'(xu_cnt);
		yo_w  = OW'(yo_cnt);
		yu_w  = OW'(yu_cnt);
	end

	// Result register and its valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			in_range_q <= fill_hit;
			if (req_type_q == hist2d_pkg::REQ_READ) begin
				bx_q <= rbx_q;
				by_q <= rby_q;
			end else if (fill_hit) begin
				bx_q <= hist2d_pkg::IDX_OUT_W'(ix);
				by_q <= hist2d_pkg::IDX_OUT_W'(iy);
			end else begin
				bx_q <= '0;
				by_q <= '0;
			end
			val_q <= val_w[hist2d_pkg::OUT_CNT_W-1:0];
			xo_q  <= xo_w[hist2d_pkg::OUT_CNT_W-1:0];
			xu_q  <= xu_w[hist2d_pkg::OUT_CNT_W-1:0];
			yo_q  <= yo_w[hist2d_pkg::OUT_CNT_W-1:0];
			yu_q  <= yu_w[hist2d_pkg::OUT_CNT_W-1:0];
		end
	end

	// Status back to the controller
	always_comb begin
		sts.is_read  = (req_type_q == hist2d_pkg::REQ_READ);
		sts.clr_last = (clr_q == AW'(DEPTH - 1));
		sts.div_last = (step_q == '0);
		sts.out_free = !out_valid_q || !out_stall;
	end

	assign out_valid     = out_valid_q;
	assign in_range      = in_range_q;
	assign bin_x_index   = bx_q;
	assign bin_y_index   = by_q;
	assign bin_value     = val_q;
	assign x_over_total  = xo_q;
	assign x_under_total = xu_q;
	assign y_over_total  = yo_q;
	assign y_under_total = yu_q;

`ifndef ASSERT_OFF
	// A new result only appears right after a finish command
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.finish))
		else $error("result valid rose without a finish");

	// Each divide step walks the quotient bit down by one
	a_step_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && (step_q != '0)) |=> (step_q == $past(step_q) - 1'b1))
		else $error("divide step counter skipped");

	// Sweep writes and fill writes never meet
	a_clr_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr |-> !cmd.finish)
		else $error("fill write during clearing sweep");
`endif

endmodule

FILE: sv/hist2d_ctrl.sv
// Controller state machine sequencing clear, classify, divide and bin update.
module hist2d_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  hist2d_pkg::sts_t sts,
	output hist2d_pkg::cmd_t cmd
);

	hist2d_pkg::state_t state_q;
	hist2d_pkg::state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hist2d_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			hist2d_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_nxt = hist2d_pkg::ST_IDLE;
			end
			hist2d_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = hist2d_pkg::ST_PREP;
			end
			hist2d_pkg::ST_PREP: begin
				state_nxt = sts.is_read ? hist2d_pkg::ST_RD : hist2d_pkg::ST_DIV;
			end
			hist2d_pkg::ST_DIV: begin
				if (sts.div_last) state_nxt = hist2d_pkg::ST_RD;
			end
			hist2d_pkg::ST_RD: begin
				state_nxt = hist2d_pkg::ST_FIN;
			end
			hist2d_pkg::ST_FIN: begin
				if (sts.out_free) state_nxt = hist2d_pkg::ST_IDLE;
			end
			default: state_nxt = hist2d_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_stall     = (state_q != hist2d_pkg::ST_IDLE);
		cmd.clr      = (state_q == hist2d_pkg::ST_CLEAR);
		cmd.load     = (state_q == hist2d_pkg::ST_IDLE) && in_valid;
		cmd.prep     = (state_q == hist2d_pkg::ST_PREP);
		cmd.div_step = (state_q == hist2d_pkg::ST_DIV);
		cmd.mem_rd   = (state_q == hist2d_pkg::ST_RD);
		cmd.finish   = (state_q == hist2d_pkg::ST_FIN) && sts.out_free;
	end

`ifndef ASSERT_OFF
	// An accepted transaction goes straight to classification
	a_accept_to_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == hist2d_pkg::ST_PREP))
		else $error("accepted transaction did not enter classify");

	// A result is never loaded over one that is still held
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result register overwritten while stalled");
`endif

endmodule

FILE: sv/histogram_2d_fixed_bins_top.sv
// Top level of the 2D fixed-width histogram with flow counters.
// Fill transactions classify an (x, y) Q16.16 sample per axis against its low and high
// edges, bump the axis over/underflow counters, and when both axes land in range
// increment bin (x * MAX_Y_BINS + y); read transactions return one stored bin. Every
// result carries the bin count plus the four saturating flow totals. One transaction is
// in flight at a time: a fill is classified, then passes through the restoring divider
// that resolves one quotient bit per cycle and the read-modify-write on the
// single-write-port bin memory before its result is registered; a read skips the
// divider and goes straight to the memory read before its result is registered. The
// block returns to idle before the next acceptance, and either kind takes longer while
// a stalled result holds the output register. The next transaction is accepted while a
// result still waits in the output register. After reset the block sweeps the bin
// memory to zero, one entry per cycle, over all MAX_X_BINS * MAX_Y_BINS entries, and
// accepts no transaction until that ends; configuration writes are taken at any time.
module histogram_2d_fixed_bins_top #(
	parameter int unsigned MAX_X_BINS  = hist2d_pkg::MAX_X_BINS_DEF,
	parameter int unsigned MAX_Y_BINS  = hist2d_pkg::MAX_Y_BINS_DEF,
	parameter int unsigned COUNT_WIDTH = hist2d_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [hist2d_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hist2d_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic signed [hist2d_pkg::EDGE_W-1:0] sample_x,
	input  logic signed [hist2d_pkg::EDGE_W-1:0] sample_y,
	input  logic [hist2d_pkg::IDX_OUT_W-1:0]     read_bin_x,
	input  logic [hist2d_pkg::IDX_OUT_W-1:0]     read_bin_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 in_range,
	output logic [hist2d_pkg::IDX_OUT_W-1:0]     bin_x_index,
	output logic [hist2d_pkg::IDX_OUT_W-1:0]     bin_y_index,
	output logic [hist2d_pkg::OUT_CNT_W-1:0]     bin_value,
	output logic [hist2d_pkg::OUT_CNT_W-1:0]     x_over_total,
	output logic [hist2d_pkg::OUT_CNT_W-1:0]     x_under_total,
	output logic [hist2d_pkg::OUT_CNT_W-1:0]     y_over_total,
	output logic [hist2d_pkg::OUT_CNT_W-1:0]     y_under_total
);

	hist2d_pkg::cmd_t cmd;
	hist2d_pkg::sts_t sts;

	// Sequencer
	hist2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath
	hist2d_dp #(
		.MAX_X_BINS  (MAX_X_BINS),
		.MAX_Y_BINS  (MAX_Y_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req_type      (req_type),
		.sample_x      (sample_x),
		.sample_y      (sample_y),
		.read_bin_x    (read_bin_x),
		.read_bin_y    (read_bin_y),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.in_range      (in_range),
		.bin_x_index   (bin_x_index),
		.bin_y_index   (bin_y_index),
		.bin_value     (bin_value),
		.x_over_total  (x_over_total),
		.x_under_total (x_under_total),
		.y_over_total  (y_over_total),
		.y_under_total (y_under_total)
	);

endmodule
